/* sv/tpb_pkg.sv */
package tpb_pkg;

    localparam int BANK_BYTES_DEF  = 2048;
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int MAX_PACKET_DEF  = 255;
    localparam int QUEUE_DEPTH     = 4;

    localparam int HDR_LEN  = 9;
    localparam int ENT_LEN  = 6;
    localparam int ENT_HDR_BYTES = 7;
    localparam int OFF_MAX_W = 16;

    localparam logic [7:0]  H4_BYTE      = 8'h04;
    localparam logic [7:0]  TRUNC_FLAG   = 8'h01;
    localparam logic [7:0]  CODE_SKIP_A  = 8'h0E;
    localparam logic [7:0]  CODE_SKIP_B  = 8'h0F;
    localparam logic [63:0] DELTA_MAX    = 64'h0000_0000_0000_FFFF;
    localparam logic [15:0] SILENCE_MAX  = 16'hFFFF;
    localparam logic [15:0] LINGER_RESET = 16'd10;
    localparam logic [3:0]  PKT_OFFSET   = 4'd15;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_BATCH  = 2'd2;

    localparam logic CFG_CAPTURE = 1'b0;
    localparam logic CFG_LINGER  = 1'b1;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [3:0]  frame_offset;
        logic [11:0] frame_length;
        logic [63:0] frame_time_us;
        logic [12:0] original_length;
        logic        truncated;
        logic [31:0] captured_count;
    } res_t;

    typedef struct packed {
        res_t                 res;
        logic                 rd_mem;
        logic                 rd_bank;
        logic [OFF_MAX_W-1:0] rd_off;
        logic [7:0]           rd_byte;
        logic                 ent_en;
        logic                 wr_bank;
        logic [OFF_MAX_W-1:0] ent_off;
        logic [8*ENT_HDR_BYTES-1:0] ent_bytes;
        logic                 dat_en;
        logic [OFF_MAX_W-1:0] dat_off;
        logic [7:0]           dat_byte;
    } job_t;

endpackage

/* sv/tpb_if.sv */
interface tpb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        first_of_event;
    logic        last_of_event;
    logic [7:0]  data_byte;
    logic [11:0] event_length;
    logic [63:0] arrival_time_us;
    logic [10:0] read_address;

    modport source (output valid, op, first_of_event, last_of_event, data_byte,
                    event_length, arrival_time_us, read_address, input ready);
    modport sink (input valid, op, first_of_event, last_of_event, data_byte,
                  event_length, arrival_time_us, read_address, output ready);
endinterface

interface tpb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [3:0]  frame_offset;
    logic [11:0] frame_length;
    logic [63:0] frame_time_us;
    logic [12:0] original_length;
    logic        truncated;
    logic [7:0]  read_data;
    logic [31:0] captured_count;

    modport source (output valid, frame_kind, frame_offset, frame_length, frame_time_us,
                    original_length, truncated, read_data, captured_count, input ready);
    modport sink (input valid, frame_kind, frame_offset, frame_length, frame_time_us,
                  original_length, truncated, read_data, captured_count, output ready);
endinterface

/* sv/timestamped_packet_batcher_top.sv */
// Event bytes enter on the events channel and each accepted word yields exactly one result
// word. Words that write no memory, and plain event data bytes, pass at one per cycle
// when the queue has room and results are taken; the first byte of a kept event is slower
// in the back end, because its six entry header bytes, the H4 byte and the first data byte
// are written one at a time through the single write port of the bank memory. A four-word
// queue between classifier and memory sequencer absorbs these bursts, and a result register
// lets the next word write memory while a result waits. Memory needs no clearing after reset.
module timestamped_packet_batcher_top #(
    parameter int BANK_BYTES  = tpb_pkg::BANK_BYTES_DEF,
    parameter int MAX_ENTRIES = tpb_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PACKET  = tpb_pkg::MAX_PACKET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    tpb_in_if.sink      events,
    tpb_out_if.source   results
);
    import tpb_pkg::*;

    job_t job, head;
    logic push, pop, empty, full;

    tpb_front #(
        .BANK_BYTES(BANK_BYTES),
        .MAX_ENTRIES(MAX_ENTRIES),
        .MAX_PACKET(MAX_PACKET)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .events(events),
        .q_full(full),
        .push(push),
        .job(job)
    );

    tpb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .din(job),
        .pop(pop),
        .head(head),
        .empty(empty),
        .full(full)
    );

    tpb_back #(
        .BANK_BYTES(BANK_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .empty(empty),
        .pop(pop),
        .results(results)
    );

endmodule

/* sv/tpb_front.sv */
module tpb_front #(
    parameter int BANK_BYTES  = tpb_pkg::BANK_BYTES_DEF,
    parameter int MAX_ENTRIES = tpb_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PACKET  = tpb_pkg::MAX_PACKET_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data,
    tpb_in_if.sink        events,
    input  logic          q_full,
    output logic          push,
    output tpb_pkg::job_t job
);
    import tpb_pkg::*;

    localparam int FILL_W = $clog2(BANK_BYTES + 1);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ROOM   = BANK_BYTES - HDR_LEN - ENT_LEN;
    localparam int CAP    = (MAX_PACKET < ROOM) ? MAX_PACKET : ROOM;

    typedef struct packed {
        logic              bank;
        logic [FILL_W-1:0] fill;
        logic [CNT_W-1:0]  cnt;
        logic [63:0]       base;
        logic [63:0]       last;
        logic [7:0]        left;
        logic              acc;
        logic [15:0]       silence;
        logic              armed;
        logic [31:0]       total;
        logic [12:0]       p_full;
        logic              p_trunc;
        logic [7:0]        p_take;
    } fst_t;

    typedef struct packed {
        fst_t s;
        res_t r;
        logic hw;
    } close_t;

    function automatic close_t do_close(fst_t s);
        close_t c;
        c = '0;
        c.s = s;
        if (s.cnt == CNT_W'(1)) begin
            c.r.frame_kind      = KIND_PACKET;
            c.r.frame_offset    = PKT_OFFSET;
            c.r.frame_length    = {4'd0, s.p_take};
            c.r.frame_time_us   = s.base;
            c.r.original_length = s.p_full;
            c.r.truncated       = s.p_trunc;
        end else if (s.cnt != '0) begin
            c.r.frame_kind    = KIND_BATCH;
            c.r.frame_length  = 12'(32'(s.fill));
            c.r.frame_time_us = s.base;
            c.hw = 1'b1;
        end
        if (s.cnt != '0) begin
            c.s.bank = ~s.bank;
            c.s.fill = FILL_W'(HDR_LEN);
            c.s.cnt  = '0;
        end
        c.s.acc     = 1'b0;
        c.s.left    = '0;
        c.s.armed   = 1'b0;
        c.s.silence = '0;
        return c;
    endfunction

    fst_t        st_reg, st_next;
    logic        cap_en_reg;
    logic [15:0] linger_reg;
    logic [63:0] hdr_time_reg [2];
    logic [7:0]  hdr_cnt_reg [2];
    logic        hdr_we;
    logic        hdr_bank;
    logic [63:0] hdr_time;
    logic [7:0]  hdr_cnt;

    fst_t        s;
    close_t      c;
    logic [12:0] full;
    logic [7:0]  take;
    logic        trunc;
    logic [63:0] diff;
    logic [15:0] dt;
    logic        rb;

    assign events.ready = !q_full;
    assign push = events.valid && !q_full;

    always_comb
    begin
        s = st_reg;
        c = '0;
        job = '0;
        hdr_we = 1'b0;
        hdr_bank = st_reg.bank;
        hdr_time = st_reg.base;
        hdr_cnt = 8'(32'(st_reg.cnt));
        full = {1'b0, events.event_length} + 13'd1;
        trunc = 32'(full) > CAP;
        take = trunc ? 8'(CAP) : full[7:0];
        diff = events.arrival_time_us - st_reg.last;
        dt = '0;
        rb = ~st_reg.bank;
        case (op_t'(events.op))
            OP_EVENT:
            begin
                if (events.first_of_event)
                begin
                    s.acc = 1'b0;
                    s.left = '0;
                    if (cap_en_reg && events.event_length != '0 &&
                        events.data_byte != CODE_SKIP_A && events.data_byte != CODE_SKIP_B)
                    begin
                        if (s.cnt != '0 && (events.arrival_time_us < s.last || diff > DELTA_MAX ||
                            32'(s.fill) + ENT_LEN + 32'(take) > BANK_BYTES ||
                            32'(s.cnt) >= MAX_ENTRIES))
                        begin
                            c = do_close(s);
                            job.res = c.r;
                            hdr_we = c.hw;
                            s = c.s;
                        end
                        if (s.cnt == '0)
                        begin
                            s.base = events.arrival_time_us;
                            s.last = events.arrival_time_us;
                            s.p_full = full;
                            s.p_trunc = trunc;
                            s.p_take = take;
                            dt = '0;
                        end
                        else
                        begin
                            dt = diff[15:0];
                        end
                        job.ent_en = 1'b1;
                        job.wr_bank = s.bank;
                        job.ent_off = OFF_MAX_W'(32'(s.fill));
                        job.ent_bytes = {H4_BYTE, take, trunc ? TRUNC_FLAG : 8'd0,
                                         {3'd0, full[12:8]}, full[7:0], dt[15:8], dt[7:0]};
                        s.fill = FILL_W'(32'(s.fill) + ENT_LEN + 32'(take));
                        s.left = take - 8'd1;
                        s.last = events.arrival_time_us;
                        s.cnt = s.cnt + CNT_W'(1);
                        s.total = s.total + 32'd1;
                        s.acc = 1'b1;
                        s.armed = 1'b1;
                        s.silence = '0;
                    end
                end
                if (s.acc)
                begin
                    if (s.left != '0)
                    begin
                        job.dat_en = 1'b1;
                        job.wr_bank = s.bank;
                        job.dat_off = OFF_MAX_W'(32'(s.fill) - 32'(s.left));
                        job.dat_byte = events.data_byte;
                        s.left = s.left - 8'd1;
                    end
                    if (events.last_of_event)
                    begin
                        s.acc = 1'b0;
                        s.left = '0;
                        if (32'(s.cnt) >= MAX_ENTRIES)
                        begin
                            hdr_bank = s.bank;
                            hdr_time = s.base;
                            hdr_cnt = 8'(32'(s.cnt));
                            c = do_close(s);
                            job.res = c.r;
                            hdr_we = c.hw;
                            s = c.s;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (s.armed)
                begin
                    if (s.silence != SILENCE_MAX)
                    begin
                        s.silence = s.silence + 16'd1;
                    end
                    if (s.silence >= linger_reg)
                    begin
                        c = do_close(s);
                        job.res = c.r;
                        hdr_we = c.hw;
                        s = c.s;
                    end
                end
            end
            OP_FLUSH:
            begin
                c = do_close(s);
                job.res = c.r;
                hdr_we = c.hw;
                s = c.s;
            end
            OP_READ:
            begin
                job.rd_bank = rb;
                if (32'(events.read_address) < HDR_LEN)
                begin
                    if (32'(events.read_address) == HDR_LEN - 1)
                    begin
                        job.rd_byte = hdr_cnt_reg[rb];
                    end
                    else
                    begin
                        job.rd_byte = 8'(hdr_time_reg[rb] >> {events.read_address[2:0], 3'd0});
                    end
                end
                else if (32'(events.read_address) < BANK_BYTES)
                begin
                    job.rd_mem = 1'b1;
                    job.rd_off = OFF_MAX_W'(32'(events.read_address));
                end
            end
            default:
            begin
                s = st_reg;
            end
        endcase
        job.res.captured_count = s.total;
        st_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            st_reg.fill <= FILL_W'(HDR_LEN);
            cap_en_reg <= 1'b0;
            linger_reg <= LINGER_RESET;
        end
        else
        begin
            if (push)
            begin
                st_reg <= st_next;
            end
            if (cfg_we && cfg_index == CFG_CAPTURE)
            begin
                cap_en_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_LINGER)
            begin
                linger_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && hdr_we)
        begin
            hdr_time_reg[hdr_bank] <= hdr_time;
            hdr_cnt_reg[hdr_bank] <= hdr_cnt;
        end
    end

endmodule

/* sv/tpb_queue.sv */
module tpb_queue #(
    parameter int DEPTH = tpb_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tpb_pkg::job_t din,
    input  logic          pop,
    output tpb_pkg::job_t head,
    output logic          empty,
    output logic          full
);
    import tpb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_ok, pop_ok;

    assign empty = count_reg == '0;
    assign full = 32'(count_reg) == DEPTH;
    assign push_ok = push && !full;
    assign pop_ok = pop && !empty;
    assign head = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("word queue count exceeds its depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !pop_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("word queue count missed a push");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("word queue pointers differ while empty");

endmodule

/* sv/tpb_back.sv */
module tpb_back #(
    parameter int BANK_BYTES = tpb_pkg::BANK_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tpb_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    tpb_out_if.source     results
);
    import tpb_pkg::*;

    localparam int OFF_W = $clog2(BANK_BYTES);

    logic [7:0]       mem [2][BANK_BYTES];
    logic [2:0]       step_reg, step_next;
    logic             out_valid_reg;
    res_t             out_res_reg;
    logic             use_mem_reg;
    logic [7:0]       rbyte_reg;
    logic [7:0]       memq_reg;
    logic [3:0]       nw;
    logic             done;
    logic             we;
    logic [OFF_W-1:0] w_off;
    logic [7:0]       w_data;

    always_comb
    begin
        nw = (head.ent_en ? 4'(ENT_HDR_BYTES) : 4'd0) + (head.dat_en ? 4'd1 : 4'd0);
        we = !empty && ({1'b0, step_reg} < nw);
        done = (nw == 4'd0) || ({1'b0, step_reg} >= nw - 4'd1);
        pop = !empty && done && (!out_valid_reg || results.ready);
        if (head.ent_en && 32'(step_reg) < ENT_HDR_BYTES)
        begin
            w_off = OFF_W'(32'(head.ent_off) + 32'(step_reg));
            w_data = head.ent_bytes[{step_reg, 3'd0} +: 8];
        end
        else
        begin
            w_off = OFF_W'(32'(head.dat_off));
            w_data = head.dat_byte;
        end
        if (pop)
        begin
            step_next = '0;
        end
        else if (we && ({1'b0, step_reg} < nw - 4'd1))
        begin
            step_next = step_reg + 3'd1;
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_res_reg <= head.res;
            use_mem_reg <= head.rd_mem;
            rbyte_reg <= head.rd_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[head.wr_bank][w_off] <= w_data;
        end
        if (pop)
        begin
            memq_reg <= mem[head.rd_bank][OFF_W'(32'(head.rd_off))];
        end
    end

    assign results.valid = out_valid_reg;
    assign results.frame_kind = out_res_reg.frame_kind;
    assign results.frame_offset = out_res_reg.frame_offset;
    assign results.frame_length = out_res_reg.frame_length;
    assign results.frame_time_us = out_res_reg.frame_time_us;
    assign results.original_length = out_res_reg.original_length;
    assign results.truncated = out_res_reg.truncated;
    assign results.captured_count = out_res_reg.captured_count;
    assign results.read_data = use_mem_reg ? memq_reg : rbyte_reg;

endmodule
